@@ rtl/wavp_pkg.sv @@
// Package for the WAV header parser: transfer structs, parse phases, result kinds
// and the RIFF/WAVE tag constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wavp_pkg;

  // Tags as they read when four bytes are gathered little-endian.
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] FMT_MIN  = 32'd16;

  // Last byte index of the RIFF/WAVE header, of a chunk header and of the fmt fields.
  localparam logic [3:0] HDR_LAST  = 4'd11;
  localparam logic [3:0] CHDR_LAST = 4'd7;
  localparam logic [3:0] FMT_LAST  = 4'd15;

  typedef enum logic [2:0] {
    PH_HDR  = 3'd0,
    PH_CHDR = 3'd1,
    PH_FMT  = 3'd2,
    PH_SKIP = 3'd3,
    PH_PAD  = 3'd4,
    PH_DATA = 3'd5,
    PH_DONE = 3'd6,
    PH_DEAD = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PCM     = 2'd0,
    KIND_SUMMARY = 2'd1,
    KIND_BAD_HDR = 2'd2,
    KIND_NO_DATA = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  pcm_byte;
    logic        pcm_last;
    logic [15:0] audio_format;
    logic [15:0] channel_count;
    logic [31:0] sample_freq;
    logic [15:0] sample_bits;
    logic [31:0] data_length;
  } out_item_t;

  // Result of one parse step, handed from the core to the output register.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } step_res_t;

endpackage

`default_nettype wire

@@ rtl/wavp_in_stage.sv @@
// Input register of the WAV header parser: holds one accepted byte for the core.
// Depends on wavp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wavp_in_stage
  import wavp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_data_i,
  input  wire logic     advance_i,
  output logic          valid_o,
  output in_item_t      data_o
);

  logic     valid_q, valid_d;
  in_item_t data_q;

  // Take a new byte when the register is empty or the held one leaves this cycle.
  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

@@ rtl/wavp_core.sv @@
// Parse core of the WAV header parser: phase machine, chunk counters, fmt fields
// and the per-byte result. Depends on wavp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wavp_core
  import wavp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     step_i,
  input  wire in_item_t item_i,
  output step_res_t     res_o
);

  phase_e      phase_q, phase_d;
  logic [3:0]  pos_q, pos_d;
  logic [31:0] word_q, word_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] len_q, len_d;
  logic [31:0] rem_q, rem_d;
  logic [15:0] fmt_q, fmt_d;
  logic [15:0] chan_q, chan_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] bits_q, bits_d;

  logic [31:0] gathered;
  logic [31:0] rem_dec;
  logic [31:0] fmt_left;
  logic        hdr_good;
  logic        is_fmt;

  assign gathered = ((pos_q[1:0] == 2'd0) ? 32'd0 : word_q) |
                    (32'(item_i.byte_value) << {pos_q[1:0], 3'b000});
  assign rem_dec  = rem_q - 32'd1;
  assign fmt_left = len_q - FMT_MIN;
  assign hdr_good = (tag_q == TAG_RIFF) && (gathered == TAG_WAVE);
  assign is_fmt   = (tag_q == TAG_FMT) && (gathered >= FMT_MIN);

  // Next state of the parse
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    word_d  = word_q;
    tag_d   = tag_q;
    len_d   = len_q;
    rem_d   = rem_q;
    fmt_d   = fmt_q;
    chan_d  = chan_q;
    rate_d  = rate_q;
    bits_d  = bits_q;
    case (phase_q)
      PH_HDR: begin
        word_d = gathered;
        if (pos_q == 4'd3) begin
          tag_d = gathered;
        end
        if (pos_q >= HDR_LAST) begin
          pos_d   = 4'd0;
          phase_d = hdr_good ? PH_CHDR : PH_DEAD;
        end else begin
          pos_d = pos_q + 4'd1;
        end
      end
      PH_CHDR: begin
        word_d = gathered;
        if (pos_q == 4'd3) begin
          tag_d = gathered;
        end
        if (pos_q >= CHDR_LAST) begin
          len_d = gathered;
          pos_d = 4'd0;
          if (is_fmt) begin
            phase_d = PH_FMT;
          end else if (tag_q == TAG_DATA) begin
            rem_d   = gathered;
            phase_d = (gathered != 32'd0) ? PH_DATA : PH_DONE;
          end else if (gathered != 32'd0) begin
            rem_d   = gathered;
            phase_d = PH_SKIP;
          end else begin
            phase_d = PH_CHDR;
          end
        end else begin
          pos_d = pos_q + 4'd1;
        end
      end
      PH_FMT: begin
        word_d = gathered;
        if (pos_q == 4'd1) begin
          fmt_d = gathered[15:0];
        end else if (pos_q == 4'd3) begin
          chan_d = gathered[31:16];
        end else if (pos_q == 4'd7) begin
          rate_d = gathered;
        end
        if (pos_q >= FMT_LAST) begin
          bits_d = gathered[31:16];
          pos_d  = 4'd0;
          if (fmt_left != 32'd0) begin
            rem_d   = fmt_left;
            phase_d = PH_SKIP;
          end else begin
            phase_d = len_q[0] ? PH_PAD : PH_CHDR;
          end
        end else begin
          pos_d = pos_q + 4'd1;
        end
      end
      PH_SKIP: begin
        rem_d = rem_dec;
        if (rem_dec == 32'd0) begin
          pos_d   = 4'd0;
          phase_d = len_q[0] ? PH_PAD : PH_CHDR;
        end
      end
      PH_PAD: begin
        pos_d   = 4'd0;
        phase_d = PH_CHDR;
      end
      PH_DATA: begin
        rem_d = rem_dec;
        if (rem_dec == 32'd0) begin
          phase_d = PH_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  // Result of this byte
  always_comb begin
    res_o = '0;
    case (phase_q)
      PH_HDR: begin
        if (pos_q >= HDR_LAST && !hdr_good) begin
          res_o.valid     = 1'b1;
          res_o.item.kind = KIND_BAD_HDR;
        end
      end
      PH_CHDR: begin
        if (pos_q >= CHDR_LAST && !is_fmt && tag_q == TAG_DATA) begin
          res_o.valid              = 1'b1;
          res_o.item.kind          = KIND_SUMMARY;
          res_o.item.audio_format  = fmt_q;
          res_o.item.channel_count = chan_q;
          res_o.item.sample_freq   = rate_q;
          res_o.item.sample_bits   = bits_q;
          res_o.item.data_length   = gathered;
        end
      end
      PH_DATA: begin
        res_o.valid         = 1'b1;
        res_o.item.kind     = KIND_PCM;
        res_o.item.pcm_byte = item_i.byte_value;
        res_o.item.pcm_last = (rem_dec == 32'd0) || item_i.end_of_file;
      end
      default: begin
      end
    endcase
    // File end with nothing emitted: report what was missing.
    if (item_i.end_of_file && !res_o.valid) begin
      if (phase_d == PH_HDR) begin
        res_o.valid     = 1'b1;
        res_o.item.kind = KIND_BAD_HDR;
      end else if (phase_d inside {PH_CHDR, PH_FMT, PH_SKIP, PH_PAD}) begin
        res_o.valid     = 1'b1;
        res_o.item.kind = KIND_NO_DATA;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR;
      pos_q   <= '0;
      word_q  <= '0;
      tag_q   <= '0;
      len_q   <= '0;
      rem_q   <= '0;
      fmt_q   <= '0;
      chan_q  <= '0;
      rate_q  <= '0;
      bits_q  <= '0;
    end else if (step_i) begin
      if (item_i.end_of_file) begin
        // Return to start after the last byte of the file.
        phase_q <= PH_HDR;
        pos_q   <= '0;
        word_q  <= '0;
        tag_q   <= '0;
        len_q   <= '0;
        rem_q   <= '0;
        fmt_q   <= '0;
        chan_q  <= '0;
        rate_q  <= '0;
        bits_q  <= '0;
      end else begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        word_q  <= word_d;
        tag_q   <= tag_d;
        len_q   <= len_d;
        rem_q   <= rem_d;
        fmt_q   <= fmt_d;
        chan_q  <= chan_d;
        rate_q  <= rate_d;
        bits_q  <= bits_d;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/wavp_out_stage.sv @@
// Output register of the WAV header parser: holds one result until taken.
// Depends on wavp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wavp_out_stage
  import wavp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      load_i,
  input  wire step_res_t res_i,
  input  wire logic      out_ready_i,
  output logic           out_valid_o,
  output out_item_t      out_data_o
);

  logic      valid_q, valid_d;
  out_item_t data_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = res_i.valid;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_i.valid) begin
      data_q <= res_i.item;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

@@ rtl/wav_header_parser.sv @@
// Top level of the WAV header parser: input register, parse core, output register.
// Depends on wavp_pkg, wavp_in_stage, wavp_core, wavp_out_stage.
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+----------------------------------
//   in      | input     | in_valid_i / in_ready_o | in_data_i  (byte, end-of-file)
//   out     | output    | out_valid_o/out_ready_i | out_data_o (kind, pcm, summary)
//
// One byte per cycle while the output does not stall; each byte waits in the input
// register until it advances, and its result is then written into the output register,
// from where it can transfer.
// The rate is set by the single parse step between the input and output registers.
// Reset (rst_ni low) puts the parser at the start of a file with both registers empty.
// A stalled output holds its result; the input register then holds one more byte
// and in_ready_o drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module wav_header_parser
  import wavp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_data_o
);

  logic      byte_valid;
  in_item_t  byte_item;
  logic      advance;
  step_res_t step_res;

  // Advance the held byte when the output register is empty or being drained.
  assign advance = byte_valid && (!out_valid_o || out_ready_i);

  wavp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .advance_i  (advance),
    .valid_o    (byte_valid),
    .data_o     (byte_item)
  );

  // Parse one byte per advance; state updates only then.
  wavp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (byte_item),
    .res_o  (step_res)
  );

  // Capture the result, or drop the slot for a byte that yields none.
  wavp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_i       (step_res),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ rtl/wavp_checker.sv @@
// Port-level checker for the WAV header parser, bound to the top level.
// Depends on wavp_pkg and wav_header_parser.
`timescale 1ns / 1ps
`default_nettype none

module wavp_checker
  import wavp_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_item_t out_data_o
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Input backpressure only comes from a stalled output.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output stall");

  // A new result follows an earlier byte transfer.
  a_out_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without a matching transfer");

  // Only a summary carries summary fields; only pcm carries the last mark.
  a_field_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind != KIND_SUMMARY) |->
      (out_data_o.audio_format == 16'd0) && (out_data_o.sample_freq == 32'd0) &&
      (out_data_o.data_length == 32'd0) &&
      ((out_data_o.kind == KIND_PCM) || !out_data_o.pcm_last))
    else $error("stray fields in result");

endmodule

bind wav_header_parser wavp_checker u_wavp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

@@ tb/sv/wav_header_parser_test.sv @@
// Testbench for wav_header_parser: random and directed WAV byte streams with a
// scoreboard class that predicts every result transfer and checks it field by field.
// Depends on wavp_pkg and the wav_header_parser RTL.
`timescale 1ns / 1ps

module wav_header_parser_test;
  import wavp_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 7;
  localparam int BYTE_TARGET  = 1850;
  // Two register stages between a byte and its result; leave some margin.
  localparam int SETTLE_CYCLES = 8;
  // Longest legal quiet stretch is a long sender gap on top of a long stall.
  localparam int STALL_LIMIT = 2000;

  // Parser state mirror: predicts the results caused by each byte transfer
  // and holds them until the matching output transfer arrives.
  class parse_scoreboard;
    phase_e      phase;
    logic [3:0]  pos;
    logic [31:0] word;
    logic [31:0] tag;
    logic [31:0] clen;
    logic [31:0] remaining;
    logic [15:0] fmt_code;
    logic [15:0] chans;
    logic [31:0] srate;
    logic [15:0] bits;
    out_item_t   expected_results[$];
    int          mismatches;

    function new();
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      phase     = PH_HDR;
      pos       = '0;
      word      = '0;
      tag       = '0;
      clen      = '0;
      remaining = '0;
      fmt_code  = '0;
      chans     = '0;
      srate     = '0;
      bits      = '0;
    endfunction

    // Assemble little-endian 32-bit words from the byte stream.
    function void gather(logic [7:0] b);
      if (pos[1:0] == 2'd0) word = '0;
      word |= {24'd0, b} << (8 * int'(pos[1:0]));
    endfunction

    // Leave a chunk body: skip what is left, then the pad byte of an odd chunk.
    function void close_chunk(logic [31:0] left);
      pos = '0;
      if (left != 0) begin
        remaining = left;
        phase = PH_SKIP;
      end else if (clen[0]) begin
        phase = PH_PAD;
      end else begin
        phase = PH_CHDR;
      end
    endfunction

    function out_item_t form_result(kind_e k, logic [7:0] pb, logic last);
      out_item_t r;
      r = '0;
      r.kind = k;
      r.pcm_byte = pb;
      r.pcm_last = last;
      if (k == KIND_SUMMARY) begin
        r.audio_format  = fmt_code;
        r.channel_count = chans;
        r.sample_freq   = srate;
        r.sample_bits   = bits;
        r.data_length   = clen;
      end
      return r;
    endfunction

    function void note_byte(in_item_t it);
      bit emitted;
      emitted = 1'b0;
      case (phase)
        PH_HDR: begin
          gather(it.byte_value);
          if (pos == 4'd3) tag = word;
          if (pos >= HDR_LAST) begin
            pos = '0;
            if (tag == TAG_RIFF && word == TAG_WAVE) begin
              phase = PH_CHDR;
            end else begin
              phase = PH_DEAD;
              expected_results.push_back(form_result(KIND_BAD_HDR, 8'd0, 1'b0));
              emitted = 1'b1;
            end
          end else begin
            pos++;
          end
        end
        PH_CHDR: begin
          gather(it.byte_value);
          if (pos == 4'd3) tag = word;
          if (pos >= CHDR_LAST) begin
            clen = word;
            pos = '0;
            if (tag == TAG_FMT && clen >= FMT_MIN) begin
              phase = PH_FMT;
            end else if (tag == TAG_DATA) begin
              expected_results.push_back(form_result(KIND_SUMMARY, 8'd0, 1'b0));
              emitted = 1'b1;
              remaining = clen;
              phase = (clen != 0) ? PH_DATA : PH_DONE;
            end else begin
              close_chunk(clen);
            end
          end else begin
            pos++;
          end
        end
        PH_FMT: begin
          gather(it.byte_value);
          if (pos == 4'd1) fmt_code = word[15:0];
          else if (pos == 4'd3) chans = word[31:16];
          else if (pos == 4'd7) srate = word;
          if (pos >= FMT_LAST) begin
            bits = word[31:16];
            close_chunk(clen - FMT_MIN);
          end else begin
            pos++;
          end
        end
        PH_SKIP: begin
          remaining--;
          if (remaining == 0) close_chunk(32'd0);
        end
        PH_PAD: begin
          phase = PH_CHDR;
          pos = '0;
        end
        PH_DATA: begin
          remaining--;
          expected_results.push_back(form_result(KIND_PCM, it.byte_value,
                                                 (remaining == 0) || it.end_of_file));
          emitted = 1'b1;
          if (remaining == 0) phase = PH_DONE;
        end
        default: ;
      endcase
      if (it.end_of_file) begin
        if (!emitted) begin
          if (phase == PH_HDR)
            expected_results.push_back(form_result(KIND_BAD_HDR, 8'd0, 1'b0));
          else if (phase inside {PH_CHDR, PH_FMT, PH_SKIP, PH_PAD})
            expected_results.push_back(form_result(KIND_NO_DATA, 8'd0, 1'b0));
        end
        clear();
      end
    endfunction

    function bit field_differs(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      bit        bad;
      if (expected_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual kind %0d byte 0x%0h",
                 $time, got.kind, got.pcm_byte);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      bad = 1'b0;
      bad |= field_differs("kind", 32'(want.kind), 32'(got.kind));
      bad |= field_differs("pcm_byte", 32'(want.pcm_byte), 32'(got.pcm_byte));
      bad |= field_differs("pcm_last", 32'(want.pcm_last), 32'(got.pcm_last));
      bad |= field_differs("audio_format", 32'(want.audio_format), 32'(got.audio_format));
      bad |= field_differs("channel_count", 32'(want.channel_count),
                           32'(got.channel_count));
      bad |= field_differs("sample_freq", want.sample_freq, got.sample_freq);
      bad |= field_differs("sample_bits", 32'(want.sample_bits), 32'(got.sample_bits));
      bad |= field_differs("data_length", want.data_length, got.data_length);
      if (bad) mismatches++;
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;

  parse_scoreboard board;
  logic [7:0]      file_bytes[$];   // bytes of the file being sent
  int              bytes_sent;
  bit              sender_steady;   // no gaps for the current file

  wav_header_parser DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Sample both channels at the edge: note every byte transfer before checking
  // the result transfer of the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) board.note_byte(in_data_i);
      if (out_valid_o && out_ready_i) board.check_result(out_data_o);
    end
  end

  // Receiver: mostly ready, short stalls often, long stalls now and then, and
  // some long stretches of steady ready.
  initial begin
    int stall_left;
    int steady_left;
    int r;
    out_ready_i = 1'b0;
    stall_left  = 0;
    steady_left = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (steady_left > 0) begin
        out_ready_i <= 1'b1;
        steady_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          steady_left = $urandom_range(40, 200);
          out_ready_i <= 1'b1;
        end else if (r < 8) begin
          stall_left = $urandom_range(8, 40);
          out_ready_i <= 1'b0;
        end else if (r < 30) begin
          stall_left = $urandom_range(0, 2);
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  // Watchdog: end the run when neither channel has moved for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  // Append n bytes of w, least significant first, as RIFF stores them.
  function automatic void push_word(logic [31:0] w, int n);
    for (int k = 0; k < n; k++) file_bytes.push_back(w[8*k +: 8]);
  endfunction

  function automatic void push_noise(int n);
    repeat (n) file_bytes.push_back(8'($urandom));
  endfunction

  // Build one random file. Most are well formed with random content; the rest
  // are noise, corrupt headers, unterminated chunks, missing data or cut short.
  function automatic void compose_file();
    int          style;
    int          chunks;
    int          len;
    int          cut;
    logic [31:0] dlen;
    logic [31:0] ctag;
    bit          open_ended;
    file_bytes.delete();
    open_ended = 1'b0;
    style = $urandom_range(0, 19);
    if (style == 0) begin
      push_noise($urandom_range(1, 30));
      return;
    end
    push_word(TAG_RIFF, 4);
    push_word($urandom, 4);
    push_word(TAG_WAVE, 4);
    if (style == 1) file_bytes[$urandom_range(0, 11)] ^= 8'($urandom_range(1, 255));
    chunks = $urandom_range(0, 3);
    for (int c = 0; c < chunks && !open_ended; c++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // fmt chunk, sometimes with extra bytes past the 16 we use
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
          push_word(TAG_FMT, 4);
          push_word(32'(16 + len), 4);
          push_word($urandom_range(0, 1) ? 32'd1 : $urandom, 2);
          push_word($urandom_range(0, 1) ? 32'($urandom_range(1, 2)) : $urandom, 2);
          push_word($urandom, 4);
          push_word($urandom, 4);
          push_word($urandom, 2);
          push_word($urandom, 2);
          push_noise(len);
          if (len % 2 == 1) push_noise(1);
        end
        4: begin
          // fmt too short to use: skipped whole
          len = $urandom_range(0, 15);
          push_word(TAG_FMT, 4);
          push_word(32'(len), 4);
          push_noise(len);
          if (len % 2 == 1) push_noise(1);
        end
        5: begin
          // chunk far longer than the file: the file end lands inside it
          ctag = $urandom_range(0, 1) ? TAG_FMT : $urandom;
          push_word(ctag, 4);
          push_word($urandom_range(0, 1) ? 32'hFFFF_FFFF : ($urandom | 32'h8000_0000), 4);
          push_noise($urandom_range(0, 30));
          open_ended = 1'b1;
        end
        default: begin
          len = $urandom_range(0, 9);
          push_word($urandom, 4);
          push_word(32'(len), 4);
          push_noise(len);
          if (len % 2 == 1) push_noise(1);
        end
      endcase
    end
    if (!open_ended && $urandom_range(0, 9) != 0) begin
      if ($urandom_range(0, 14) == 0)
        dlen = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom;
      else
        dlen = 32'($urandom_range(0, 24));
      push_word(TAG_DATA, 4);
      push_word(dlen, 4);
      if (dlen <= 64) begin
        push_noise(int'(dlen));
        push_noise($urandom_range(0, 3));
      end else begin
        push_noise($urandom_range(1, 40));
      end
    end
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
    end
  endfunction

  // Hold valid low for a random gap: mostly none or short, sometimes long.
  task automatic pause_sender();
    int r;
    int gap;
    gap = 0;
    if (!sender_steady) begin
      r = $urandom_range(0, 99);
      if (r >= 92) gap = $urandom_range(8, 40);
      else if (r >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Send the current file; flag its last byte as the end of the file.
  task automatic send_file();
    in_item_t it;
    foreach (file_bytes[i]) begin
      pause_sender();
      it.byte_value  = file_bytes[i];
      it.end_of_file = (i == file_bytes.size() - 1);
      in_valid_i <= 1'b1;
      in_data_i  <= it;
      // hold the transfer until ready is seen at an edge
      do @(posedge clk_i); while (!in_ready_o);
      bytes_sent++;
    end
  endtask

  // Drop valid and wait until every predicted result has come out. Look at the
  // queue only from the next edge on, once the last byte has been noted.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.expected_results.size() != 0);
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    bytes_sent    = 0;
    sender_steady = 1'b0;
    board = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // File end on the very first byte: header too short.
    file_bytes.delete();
    file_bytes.push_back(8'h00);
    send_file();

    // Broken WAVE tag, then one more byte that the parser must ignore.
    file_bytes.delete();
    push_word(TAG_RIFF, 4);
    push_word(32'hFFFF_FFFF, 4);
    push_word(TAG_WAVE ^ 32'h8000_0000, 4);
    file_bytes.push_back(8'hFF);
    send_file();

    // Good header ending right at its last byte: no data chunk.
    file_bytes.delete();
    push_word(TAG_RIFF, 4);
    push_word(32'd0, 4);
    push_word(TAG_WAVE, 4);
    send_file();

    // Let the pipeline run empty once before the random files.
    drain_results();

    while (bytes_sent < BYTE_TARGET) begin
      sender_steady = ($urandom_range(0, 3) == 0);
      compose_file();
      send_file();
      if ($urandom_range(0, 5) == 0) drain_results();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0 && board.expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ wav_header_parser.f @@
rtl/wavp_pkg.sv
rtl/wavp_in_stage.sv
rtl/wavp_core.sv
rtl/wavp_out_stage.sv
rtl/wav_header_parser.sv
rtl/wavp_checker.sv
tb/sv/wav_header_parser_test.sv
